/* hdl/adc_pkg.sv */
// adc_pkg: shared types and constants of the ascii decimal calculator
// character codes, operator classes and the token passed from front to back
// used by adc_front, adc_queue, adc_back and ascii_decimal_calculator
package adc_pkg;

  // character codes
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_AND   = 8'd38;
  localparam logic [7:0] CH_OR    = 8'd124;
  localparam logic [7:0] CH_XOR   = 8'd94;

  // decimal radix of the accumulator
  localparam int unsigned RADIX = 10;

  // default build values
  localparam int MAX_DIGITS_DEF  = 10;
  localparam int QUEUE_DEPTH_DEF = 4;

  // width of the per-number byte counter
  localparam int CNT_W = 4;

  // operator class of a byte
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_AND,
    OP_OR,
    OP_XOR,
    OP_BAD
  } op_e;

  // classified byte as queued between front and back
  typedef struct packed {
    logic [7:0] data;
    logic       eol;
    logic       minus;
    op_e        op;
  } token_t;

endpackage

/* hdl/ascii_decimal_calculator.sv */
// result path: the byte ending the second number goes through the token queue,
//   the operand staging register and the output register; output stalls hold it
// throughput: one byte per cycle unless the queue fills; the parser's times-ten
//   accumulate is combinational; the token queue absorbs short output stalls
// reset: asynchronous, active low; queue emptied, parser back to the first number
module ascii_decimal_calculator #(
  parameter int MAX_DIGITS  = adc_pkg::MAX_DIGITS_DEF,
  parameter int QUEUE_DEPTH = adc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] result_value
  output logic        m_axis_tuser    // [0] invalid_op
);

  adc_pkg::token_t front_tok, queue_tok;
  logic            q_full, q_empty, back_ready;

  // byte classification
  adc_front u_front (
    .data_i (s_axis_tdata),
    .tok_o  (front_tok)
  );

  assign s_axis_tready = ~q_full;

  // token queue
  adc_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .data_i  (front_tok),
    .full_o  (q_full),
    .pop_i   (back_ready),
    .data_o  (queue_tok),
    .empty_o (q_empty)
  );

  // parser and alu
  adc_back #(
    .MaxDigits (MAX_DIGITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (queue_tok),
    .tok_valid_i (~q_empty),
    .tok_ready_o (back_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (m_axis_tdata),
    .invalid_o   (m_axis_tuser)
  );

endmodule

/* hdl/adc_front.sv */
// adc_front: classifies each received byte into a token
// marks line ends, the minus sign and the operator class
// depends on adc_pkg
module adc_front (
  input  logic [7:0]      data_i,
  output adc_pkg::token_t tok_o
);

  // operator class lookup
  adc_pkg::op_e op_class;

  always_comb begin
    case (data_i)
      adc_pkg::CH_PLUS:  op_class = adc_pkg::OP_ADD;
      adc_pkg::CH_MINUS: op_class = adc_pkg::OP_SUB;
      adc_pkg::CH_AND:   op_class = adc_pkg::OP_AND;
      adc_pkg::CH_OR:    op_class = adc_pkg::OP_OR;
      adc_pkg::CH_XOR:   op_class = adc_pkg::OP_XOR;
      default:           op_class = adc_pkg::OP_BAD;
    endcase
  end

  // token assembly
  always_comb begin
    tok_o.data  = data_i;
    tok_o.eol   = (data_i == adc_pkg::CH_CR) || (data_i == adc_pkg::CH_LF);
    tok_o.minus = (data_i == adc_pkg::CH_MINUS);
    tok_o.op    = op_class;
  end

endmodule

/* hdl/adc_queue.sv */
// adc_queue: small token fifo between front and back
// register storage with read and write pointers and a fill count
// depends on adc_pkg
module adc_queue #(
  parameter int Depth = adc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  adc_pkg::token_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output adc_pkg::token_t data_o,
  output logic            empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  adc_pkg::token_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign push    = push_i & ~full_o;
  assign pop     = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // token storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* hdl/adc_back.sv */
// adc_back: number parser, operand staging and result alu
// parses tokens into two signed operands and computes the result beat
// depends on adc_pkg
module adc_back #(
  parameter int MaxDigits = adc_pkg::MAX_DIGITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  adc_pkg::token_t tok_i,
  input  logic            tok_valid_i,
  output logic            tok_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [31:0]     result_o,
  output logic            invalid_o
);

  localparam int CntW = adc_pkg::CNT_W;

  localparam logic [1:0] PhNum1 = 2'd0;
  localparam logic [1:0] PhOp   = 2'd1;
  localparam logic [1:0] PhNum2 = 2'd2;

  // parser state
  logic [1:0]      phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     acc_q, acc_d;
  logic            neg_q, neg_d;
  logic [31:0]     first_m_q, first_m_d;
  logic            first_neg_q, first_neg_d;
  adc_pkg::op_e    op_q, op_d;

  // operand staging
  logic            pend_valid_q;
  logic [31:0]     pa_m_q, pb_m_q;
  logic            pa_neg_q, pb_neg_q;
  adc_pkg::op_e    pend_op_q;
  logic            pend_load, pend_go;

  // output register
  logic            out_valid_q;
  logic [31:0]     result_q;
  logic            invalid_q;

  // number step
  logic [31:0]     acc_mac;
  logic            first_minus;
  logic [31:0]     step_m;
  logic            step_neg;
  logic [CntW-1:0] cnt_inc;
  logic            num_done;
  logic            take;

  assign pend_go     = pend_valid_q & (~out_valid_q | out_ready_i);
  assign tok_ready_o = ~pend_valid_q | pend_go;
  assign take        = tok_valid_i & tok_ready_o;

  // acc * 10 + (byte - '0'), wrapping
  assign acc_mac = (acc_q << 3) + (acc_q << 1) + {24'd0, tok_i.data}
                 - {24'd0, adc_pkg::CH_ZERO};
  assign first_minus = (cnt_q == '0) && tok_i.minus;
  assign cnt_inc     = cnt_q + CntW'(1);
  assign step_m      = (tok_i.eol || first_minus) ? acc_q : acc_mac;
  assign step_neg    = neg_q | (first_minus & ~tok_i.eol);
  assign num_done    = tok_i.eol || (cnt_inc >= CntW'(MaxDigits));

  // parser sequencing
  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    first_m_d   = first_m_q;
    first_neg_d = first_neg_q;
    op_d        = op_q;
    pend_load   = 1'b0;
    if (take) begin
      case (phase_q)
        PhOp: begin
          op_d    = tok_i.op;
          phase_d = PhNum2;
        end
        default: begin
          if (num_done) begin
            cnt_d = '0;
            acc_d = '0;
            neg_d = 1'b0;
            if (phase_q == PhNum2) begin
              pend_load = 1'b1;
              phase_d   = PhNum1;
            end else begin
              first_m_d   = step_m;
              first_neg_d = step_neg;
              phase_d     = PhOp;
            end
          end else begin
            cnt_d = cnt_inc;
            acc_d = step_m;
            neg_d = step_neg;
            if (phase_q != PhNum2) begin
              phase_d = PhNum1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhNum1;
      cnt_q       <= '0;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      first_m_q   <= '0;
      first_neg_q <= 1'b0;
      op_q        <= adc_pkg::OP_BAD;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      neg_q       <= neg_d;
      first_m_q   <= first_m_d;
      first_neg_q <= first_neg_d;
      op_q        <= op_d;
    end
  end

  // staging register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else begin
      pend_valid_q <= pend_load | (pend_valid_q & ~pend_go);
    end
  end

  // staging register payload
  always_ff @(posedge clk_i) begin
    if (pend_load) begin
      pa_m_q    <= first_m_q;
      pa_neg_q  <= first_neg_q;
      pb_m_q    <= step_m;
      pb_neg_q  <= step_neg;
      pend_op_q <= op_q;
    end
  end

  // sign application and alu
  logic [31:0] va, vb, alu_res;
  logic        alu_bad;

  assign va = pa_neg_q ? (32'd0 - pa_m_q) : pa_m_q;
  assign vb = pb_neg_q ? (32'd0 - pb_m_q) : pb_m_q;

  always_comb begin
    alu_bad = 1'b0;
    case (pend_op_q)
      adc_pkg::OP_ADD: alu_res = va + vb;
      adc_pkg::OP_SUB: alu_res = va - vb;
      adc_pkg::OP_AND: alu_res = va & vb;
      adc_pkg::OP_OR:  alu_res = va | vb;
      adc_pkg::OP_XOR: alu_res = va ^ vb;
      default: begin
        alu_res = '0;
        alu_bad = 1'b1;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= pend_go | (out_valid_q & ~out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_go) begin
      result_q  <= alu_res;
      invalid_q <= alu_bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign invalid_o   = invalid_q;

  // checks
  a_cnt_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CntW'(MaxDigits))
    else $error("byte count reached the digit limit without ending the number");

  a_op_phase_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhOp) |-> (acc_q == '0) && (cnt_q == '0) && !neg_q)
    else $error("number state not cleared in operator phase");

  a_stage_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_go |=> out_valid_q)
    else $error("staged operands moved but no result beat raised");

  a_no_stage_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_valid_q && !pend_go) |-> !pend_load)
    else $error("staging register overwritten while held");

endmodule

/* sim/ascii_decimal_calculator_tb.sv */
// ascii_decimal_calculator_tb: self-checking bench for the byte-serial decimal calculator
// a scoreboard class predicts each result beat from the accepted input bytes
// depends on adc_pkg and ascii_decimal_calculator
module ascii_decimal_calculator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_DIGITS = adc_pkg::MAX_DIGITS_DEF;
  localparam int unsigned N_BYTES    = 1100;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_OPER,
    PH_SECOND
  } parse_phase_e;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_COIN,
    RX_ONE_IN_FOUR,
    RX_RARE_STALL
  } sink_mode_e;

  typedef struct packed {
    logic [31:0] value;
    logic        bad_op;
  } calc_result_t;

  // calculator prediction and result matching
  class calc_scoreboard;
    parse_phase_e phase;
    logic [3:0]   digits_taken;
    logic [31:0]  magnitude;
    logic         minus_seen;
    logic [31:0]  lhs;
    logic [7:0]   op_char;
    calc_result_t pending_q[$];
    int unsigned  errors;
    int unsigned  bytes_seen;
    int unsigned  results_seen;
    int unsigned  invalid_seen;

    function new();
      phase        = PH_FIRST;
      digits_taken = '0;
      magnitude    = '0;
      minus_seen   = 1'b0;
      lhs          = '0;
      op_char      = '0;
      errors       = 0;
      bytes_seen   = 0;
      results_seen = 0;
      invalid_seen = 0;
    endfunction

    function void clear_number();
      digits_taken = '0;
      magnitude    = '0;
      minus_seen   = 1'b0;
    endfunction

    // feed one byte to the number parser, returns 1 when the number is complete
    function bit number_ends(input logic [7:0] b, output logic [31:0] value);
      value = '0;
      if (b == adc_pkg::CH_CR || b == adc_pkg::CH_LF) begin
        value = minus_seen ? 32'd0 - magnitude : magnitude;
        clear_number();
        return 1'b1;
      end
      // leading minus only flags the sign, anything else is accumulated unchecked
      if (digits_taken == 4'd0 && b == adc_pkg::CH_MINUS) begin
        minus_seen = 1'b1;
      end else begin
        magnitude = magnitude * adc_pkg::RADIX + ({24'd0, b} - {24'd0, adc_pkg::CH_ZERO});
      end
      digits_taken = digits_taken + 4'd1;
      if (int'(digits_taken) >= MAX_DIGITS) begin
        value = minus_seen ? 32'd0 - magnitude : magnitude;
        clear_number();
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // advance the parser by one accepted byte, queue a result if one is due
    function void note_byte(input logic [7:0] b);
      logic [31:0]  value;
      calc_result_t r;
      bytes_seen++;
      case (phase)
        PH_OPER: begin
          op_char = b;
          phase   = PH_SECOND;
        end
        PH_SECOND: begin
          if (number_ends(b, value)) begin
            r.bad_op = 1'b0;
            case (op_char)
              adc_pkg::CH_PLUS:  r.value = lhs + value;
              adc_pkg::CH_MINUS: r.value = lhs - value;
              adc_pkg::CH_AND:   r.value = lhs & value;
              adc_pkg::CH_OR:    r.value = lhs | value;
              adc_pkg::CH_XOR:   r.value = lhs ^ value;
              default: begin
                r.value  = '0;
                r.bad_op = 1'b1;
              end
            endcase
            pending_q.push_back(r);
            phase = PH_FIRST;
          end
        end
        default: begin
          phase = PH_FIRST;
          if (number_ends(b, value)) begin
            lhs   = value;
            phase = PH_OPER;
          end
        end
      endcase
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // compare a result beat with the oldest expectation
    task check_result(input logic [31:0] value, input logic bad_op);
      calc_result_t r;
      if (pending_q.size() == 0) begin
        report($sformatf("result %h/%b with nothing expected", value, bad_op));
        return;
      end
      r = pending_q.pop_front();
      results_seen++;
      if (r.bad_op) invalid_seen++;
      if (value !== r.value)
        report($sformatf("result_value %h, expected %h", value, r.value));
      if (bad_op !== r.bad_op)
        report($sformatf("invalid_op %b, expected %b", bad_op, r.bad_op));
    endtask

    function int unsigned pending();
      return pending_q.size();
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  calc_scoreboard sb = new();
  int unsigned    burst_left = 0;
  int unsigned    bytes_sent = 0;

  ascii_decimal_calculator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] rx_byte
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [31:0] result_value
    .m_axis_tuser  (m_axis_tuser)    // [0] invalid_op
  );

  // 4 ns clock
  always #2 clk_i = ~clk_i;

  // check output beats before noting the input beat of the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata);
    end
  end

  // offer one byte, in bursts with random gaps between them
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // one number: optional sign, mostly decimal digits, some raw bytes
  task automatic send_number();
    int unsigned len;
    int unsigned taken;
    bit          full;
    full  = ($urandom_range(0, 9) == 0);
    len   = full ? MAX_DIGITS : $urandom_range(0, 5);
    taken = 0;
    if (len > 0 && $urandom_range(0, 3) == 0) begin
      send_byte(adc_pkg::CH_MINUS);
      taken++;
    end
    while (taken < len) begin
      send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'(adc_pkg::CH_ZERO + $urandom_range(0, 9)));
      taken++;
    end
    // a full-length number needs no terminator
    if (!full) send_byte($urandom_range(0, 1) ? adc_pkg::CH_CR : adc_pkg::CH_LF);
  endtask

  // mostly well-formed expressions, some loose noise bytes
  task automatic send_expression();
    logic [7:0] op;
    if ($urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 4))
        0:       op = adc_pkg::CH_PLUS;
        1:       op = adc_pkg::CH_MINUS;
        2:       op = adc_pkg::CH_AND;
        3:       op = adc_pkg::CH_OR;
        default: op = adc_pkg::CH_XOR;
      endcase
      if ($urandom_range(0, 4) == 0) op = 8'($urandom_range(0, 255));
      send_number();
      send_byte(op);
      send_number();
    end
  endtask

  // output side: changing stall patterns plus two long hold-offs
  initial begin : sink
    int unsigned cycle_n;
    int unsigned hold;
    sink_mode_e  mode;
    cycle_n = 0;
    hold    = 0;
    mode    = RX_STEADY;
    forever begin
      @(posedge clk_i);
      cycle_n++;
      if (cycle_n % 64 == 0) mode = sink_mode_e'($urandom_range(0, 3));
      if (cycle_n == 400 || cycle_n == 1600) hold = 150;
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          RX_STEADY:      m_axis_tready <= 1'b1;
          RX_COIN:        m_axis_tready <= 1'($urandom_range(0, 1));
          RX_ONE_IN_FOUR: m_axis_tready <= (cycle_n % 4 == 0);
          default:        m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // main sequence
  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // signed first number ended by cr, addition, second ended by lf
    send_text("-7");
    send_byte(adc_pkg::CH_CR);
    send_byte(adc_pkg::CH_PLUS);
    send_text("12");
    send_byte(adc_pkg::CH_LF);
    // empty first number, subtraction, lone minus as second number
    send_byte(adc_pkg::CH_LF);
    send_byte(adc_pkg::CH_MINUS);
    send_byte(adc_pkg::CH_MINUS);
    send_byte(adc_pkg::CH_LF);
    // byte extremes as digits, and, minus inside a number
    send_byte(8'hFF);
    send_byte(adc_pkg::CH_LF);
    send_byte(adc_pkg::CH_AND);
    send_byte(8'h00);
    send_byte(adc_pkg::CH_MINUS);
    send_byte(adc_pkg::CH_CR);
    // or with an empty second number
    send_text("3");
    send_byte(adc_pkg::CH_LF);
    send_byte(adc_pkg::CH_OR);
    send_byte(adc_pkg::CH_LF);
    // xor with a full-length overflowing second number
    send_byte(adc_pkg::CH_CR);
    send_byte(adc_pkg::CH_XOR);
    send_text("9876543210");
    // lf taken as operator gives a bad-operator result
    send_byte(adc_pkg::CH_LF);
    send_byte(adc_pkg::CH_LF);
    send_byte(adc_pkg::CH_LF);

    while (bytes_sent < N_BYTES) send_expression();
    s_axis_tvalid <= 1'b0;

    // drain outstanding results, then let trailing bytes settle
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("covered %0d bytes and %0d results, %0d of them with a bad operator",
             sb.bytes_seen, sb.results_seen, sb.invalid_seen);
    $display("directed corner cases, random expressions with noise, bursty input, stalls");
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
hdl/adc_pkg.sv
hdl/adc_front.sv
hdl/adc_queue.sv
hdl/adc_back.sv
hdl/ascii_decimal_calculator.sv
sim/ascii_decimal_calculator_tb.sv
